>>> rtl/rrts_pkg.sv
// Shared types and constants for the round-robin task scheduler.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package rrts_pkg;

  // Fixed field widths of the words on the channels.
  localparam int ID_W   = 8;
  localparam int ACT_W  = 2;
  localparam int DROP_W = 5;

  // Action codes carried in the input word.
  typedef enum logic [ACT_W-1:0] {
    ACT_CREATE = 2'd0,
    ACT_SWITCH = 2'd1,
    ACT_FINISH = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SW_POP,
    ST_SW_DATA,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ld_item;      // latch the accepted word, clear the working result
    logic create;       // hand out an identifier and queue it
    logic drop;         // discard the finished entry at the head
    logic pop_rd;       // read the live entry at the head and advance
    logic commit_ring;  // run the popped entry, re-queue the old task
    logic commit_idle;  // run the idle task, re-queue the old task
    logic fin_start;    // mark the running task and start the ring scan
    logic scan_en;      // advance the ring scan by one slot
    logic load_res;     // move the working result into the output register
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             fid_zero;
    logic             empty;
    logic             head_fin;
    logic             scan_done;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/rrts_if.sv
// Valid/ready channel interfaces for the scheduler's input and result words.
// Depends on rrts_pkg for the field widths.
`default_nettype none

interface rrts_in_if;
  logic                        valid;
  logic                        ready;
  logic [rrts_pkg::ACT_W-1:0]  action;
  logic [rrts_pkg::ID_W-1:0]   finish_id;

  modport source (output valid, output action, output finish_id, input ready);
  modport sink   (input valid, input action, input finish_id, output ready);
endinterface

interface rrts_out_if;
  logic                        valid;
  logic                        ready;
  logic [rrts_pkg::ID_W-1:0]   running_id;
  logic [rrts_pkg::ID_W-1:0]   new_id;
  logic                        accepted;
  logic [rrts_pkg::DROP_W-1:0] dropped_count;

  modport source (output valid, output running_id, output new_id, output accepted,
                  output dropped_count, input ready);
  modport sink   (input valid, input running_id, input new_id, input accepted,
                  input dropped_count, output ready);
endinterface

`default_nettype wire

>>> rtl/rrts_dp.sv
// Datapath of the scheduler: ring memory, finished marks, pointers, task state
// and the output register. Depends on rrts_pkg; driven by rrts_ctrl commands.
`default_nettype none

module rrts_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rrts_pkg::ctl_t              ctl,
  output rrts_pkg::status_t                status,
  input  wire logic [rrts_pkg::ACT_W-1:0]  in_action,
  input  wire logic [rrts_pkg::ID_W-1:0]   in_finish_id,
  output logic [rrts_pkg::ID_W-1:0]        out_running_id,
  output logic [rrts_pkg::ID_W-1:0]        out_new_id,
  output logic                             out_accepted,
  output logic [rrts_pkg::DROP_W-1:0]      out_dropped_count
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int IW = rrts_pkg::ID_W;
  localparam int DW = rrts_pkg::DROP_W;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    if (p == PW'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  // Ring storage; entries are read only while occupied, so no reset.
  logic [IW-1:0] ring_mem [QUEUE_DEPTH];
  logic [IW-1:0] rd_data_r;
  logic          rd_en;
  logic [PW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_data;

  logic [QUEUE_DEPTH-1:0] fin_r, fin_nxt;
  logic [PW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic          cur_fin_r, cur_fin_nxt;
  logic [IW-1:0] next_id_r, next_id_nxt;
  logic [PW-1:0] scan_p_r, scan_p_nxt, pend_addr_r, pend_addr_nxt;
  logic          pend_r, pend_nxt;

  // Working copy of the current word and its result.
  logic [rrts_pkg::ACT_W-1:0] act_r, act_nxt;
  logic [IW-1:0] fid_r, fid_nxt;
  logic [IW-1:0] new_r, new_nxt;
  logic          acc_r, acc_nxt;
  logic [PW-1:0] drop_r, drop_nxt;
  logic [PW+DW-1:0] drop_ext;

  logic full;

  assign full     = (ptr_inc(tail_r) == head_r);
  assign drop_ext = {{DW{1'b0}}, drop_r};

  assign status.act       = act_r;
  assign status.fid_zero  = (fid_r == '0);
  assign status.empty     = (head_r == tail_r);
  assign status.head_fin  = fin_r[head_r];
  assign status.scan_done = (scan_p_r == tail_r) && !pend_r;

  always_comb begin
    fin_nxt       = fin_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cur_nxt       = cur_r;
    cur_fin_nxt   = cur_fin_r;
    next_id_nxt   = next_id_r;
    scan_p_nxt    = scan_p_r;
    pend_addr_nxt = pend_addr_r;
    pend_nxt      = pend_r;
    act_nxt       = act_r;
    fid_nxt       = fid_r;
    new_nxt       = new_r;
    acc_nxt       = acc_r;
    drop_nxt      = drop_r;
    rd_en         = 1'b0;
    rd_addr       = head_r;
    wr_en         = 1'b0;
    wr_data       = cur_r;

    if (ctl.ld_item) begin
      act_nxt  = in_action;
      fid_nxt  = in_finish_id;
      new_nxt  = '0;
      acc_nxt  = 1'b0;
      drop_nxt = '0;
    end

    if (ctl.create) begin
      new_nxt     = next_id_r;
      next_id_nxt = (next_id_r == '1) ? IW'(1) : next_id_r + IW'(1);
      if (!full) begin
        wr_en          = 1'b1;
        wr_data        = next_id_r;
        fin_nxt[tail_r] = 1'b0;
        tail_nxt       = ptr_inc(tail_r);
        acc_nxt        = 1'b1;
      end
    end

    if (ctl.drop) begin
      head_nxt = ptr_inc(head_r);
      drop_nxt = drop_r + PW'(1);
    end

    if (ctl.pop_rd) begin
      rd_en    = 1'b1;
      rd_addr  = head_r;
      head_nxt = ptr_inc(head_r);
    end

    // The old task goes back on the ring unless it was marked finished.
    if (ctl.commit_ring || ctl.commit_idle) begin
      cur_nxt     = ctl.commit_ring ? rd_data_r : '0;
      cur_fin_nxt = 1'b0;
      if (!cur_fin_r && !full) begin
        wr_en           = 1'b1;
        wr_data         = cur_r;
        fin_nxt[tail_r] = 1'b0;
        tail_nxt        = ptr_inc(tail_r);
      end
    end

    if (ctl.fin_start) begin
      scan_p_nxt = head_r;
      pend_nxt   = 1'b0;
      if (fid_r != '0 && cur_r == fid_r) begin
        cur_fin_nxt = 1'b1;
        acc_nxt     = 1'b1;
      end
    end

    // One slot read per cycle; each slot is compared in the cycle after its read.
    if (ctl.scan_en) begin
      if (pend_r && rd_data_r == fid_r) begin
        fin_nxt[pend_addr_r] = 1'b1;
        acc_nxt              = 1'b1;
      end
      if (scan_p_r != tail_r) begin
        rd_en         = 1'b1;
        rd_addr       = scan_p_r;
        pend_addr_nxt = scan_p_r;
        scan_p_nxt    = ptr_inc(scan_p_r);
        pend_nxt      = 1'b1;
      end else begin
        pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[tail_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= ring_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r     <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      cur_r     <= '0;
      cur_fin_r <= 1'b0;
      next_id_r <= IW'(1);
      pend_r    <= 1'b0;
    end else begin
      fin_r     <= fin_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      cur_r     <= cur_nxt;
      cur_fin_r <= cur_fin_nxt;
      next_id_r <= next_id_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_p_r    <= scan_p_nxt;
    pend_addr_r <= pend_addr_nxt;
    act_r       <= act_nxt;
    fid_r       <= fid_nxt;
    new_r       <= new_nxt;
    acc_r       <= acc_nxt;
    drop_r      <= drop_nxt;
    if (ctl.load_res) begin
      out_running_id    <= cur_r;
      out_new_id        <= new_r;
      out_accepted      <= acc_r;
      out_dropped_count <= drop_ext[DW-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/rrts_ctrl.sv
// Controller of the scheduler: sequences one word at a time through the
// datapath and owns both handshakes. Depends on rrts_pkg.
`default_nettype none

module rrts_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire rrts_pkg::status_t status,
  output rrts_pkg::ctl_t         ctl
);

  rrts_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rrts_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;

    unique case (state_r)
      rrts_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.ld_item = 1'b1;
          state_nxt   = rrts_pkg::ST_DECODE;
        end
      end
      rrts_pkg::ST_DECODE: begin
        unique case (status.act)
          rrts_pkg::ACT_CREATE: begin
            ctl.create = 1'b1;
            state_nxt  = rrts_pkg::ST_DONE;
          end
          rrts_pkg::ACT_SWITCH: begin
            state_nxt = rrts_pkg::ST_SW_POP;
          end
          rrts_pkg::ACT_FINISH: begin
            ctl.fin_start = 1'b1;
            state_nxt     = status.fid_zero ? rrts_pkg::ST_DONE : rrts_pkg::ST_SCAN;
          end
          default: begin
            state_nxt = rrts_pkg::ST_DONE;
          end
        endcase
      end
      rrts_pkg::ST_SW_POP: begin
        if (status.empty) begin
          ctl.commit_idle = 1'b1;
          state_nxt       = rrts_pkg::ST_DONE;
        end else if (status.head_fin) begin
          ctl.drop = 1'b1;
        end else begin
          ctl.pop_rd = 1'b1;
          state_nxt  = rrts_pkg::ST_SW_DATA;
        end
      end
      rrts_pkg::ST_SW_DATA: begin
        ctl.commit_ring = 1'b1;
        state_nxt       = rrts_pkg::ST_DONE;
      end
      rrts_pkg::ST_SCAN: begin
        if (status.scan_done) begin
          state_nxt = rrts_pkg::ST_DONE;
        end else begin
          ctl.scan_en = 1'b1;
        end
      end
      rrts_pkg::ST_DONE: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid_r || out_ready) begin
          ctl.load_res = 1'b1;
          state_nxt    = rrts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rrts_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (ctl.load_res) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

`default_nettype wire

>>> rtl/round_robin_task_scheduler.sv
// Top level of the round-robin task scheduler: controller plus datapath.
// Depends on rrts_pkg, rrts_if.sv, rrts_ctrl and rrts_dp.
`default_nettype none

// Round-robin scheduler for task identifiers. After reset the idle task 0
// runs and the ring of waiting tasks is empty. Each input word carries an
// action: create hands out the next identifier (1 up to 255, then back to 1)
// and appends it to the ring; switch pops ring entries, discards those marked
// finished, runs the first live one (or the idle task when the ring runs dry)
// and puts the old task back on the ring unless it was finished; finish marks
// every queued entry and the running task with the given identifier, and
// identifier 0 is never marked. The ring holds QUEUE_DEPTH-1 entries. Exactly
// one result word follows each input word, with the running task, the
// created identifier, an accepted flag and the number of entries discarded.
// Words are handled one at a time by a small sequencer: create and unused
// codes pass through the decode and done states; a switch adds the pop state,
// visited again for each discarded entry, and the data state when it finds a
// live entry; a finish of identifier 0 goes straight to done, otherwise the
// scan state reads the ring, which has a single read port and is scanned one
// slot per cycle. A new input word is taken while the previous result
// still waits in the output register; it only stalls at its end until
// that register is free.

module round_robin_task_scheduler #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rrts_in_if.sink     in_word,
  rrts_out_if.source  out_word
);

  rrts_pkg::ctl_t    ctl;
  rrts_pkg::status_t status;

  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_word.valid),
    .in_ready  (in_word.ready),
    .out_valid (out_word.valid),
    .out_ready (out_word.ready),
    .status    (status),
    .ctl       (ctl)
  );

  rrts_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .status            (status),
    .in_action         (in_word.action),
    .in_finish_id      (in_word.finish_id),
    .out_running_id    (out_word.running_id),
    .out_new_id        (out_word.new_id),
    .out_accepted      (out_word.accepted),
    .out_dropped_count (out_word.dropped_count)
  );

endmodule

`default_nettype wire
